>>> sv/asl_pkg.sv
// asl_pkg: shared types and constants of the arc-length segment locator
// no dependencies; imported by arclength_segment_locator_top, asl_checker and tb_top
package asl_pkg;

  localparam int unsigned MAX_SEG  = 64;
  localparam int unsigned NUM_W    = 51;
  localparam int unsigned DEN_W    = 34;
  localparam logic [16:0] FRAC_ONE = 17'd65536;
  localparam logic [30:0] POS_CAP  = 31'h7fffffff;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_POS2PT = 3'd1,
    OP_PT2POS = 3'd2,
    OP_FIRST  = 3'd3,
    OP_LAST   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DEGEN    = 3'd1,
    ST_IDX      = 3'd2,
    ST_FRAC     = 3'd3,
    ST_ZERO     = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_COUNT = 2'd0,
    CFG_START = 2'd1,
    CFG_END   = 2'd2,
    CFG_EPS   = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WAIT,
    S_TOP,
    S_SCAN,
    S_LO,
    S_HI,
    S_MUL,
    S_DIVI,
    S_DIV,
    S_FIN,
    S_IDSCAN
  } state_e;

endpackage

>>> sv/arclength_segment_locator_top.sv
// arclength_segment_locator_top: boundary and id tables, searches and a shared
// restoring divider under one sequencer; depends on asl_pkg
//
// channel  | direction | handshake
// ---------+-----------+-------------------------------------------------
// command  | in        | start_i accepted when busy_o is low
// result   | out       | valid_o high for one cycle, cannot be held off
// config   | in        | cfg_we_i, cfg_idx_i, cfg_data_i written at once
//
// write entry and errors found up front answer in the cycle after the item
// position to point: boundary scan through the single read port, then 51 divider
//   steps, one quotient bit a cycle; positions at or above the last boundary, or
//   at or below zero, answer without the scan or the divide
// point to position: boundary reads, a multiply, then the divider; id searches scan the id table
// tables are not cleared by reset; the receiver cannot stall
module arclength_segment_locator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         op_i,
  input  logic [6:0]         entry_index_i,
  input  logic signed [31:0] arc_position_i,
  input  logic [16:0]        query_frac_i,
  input  logic [31:0]        segment_id_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [16:0]        cfg_data_i,
  output logic               valid_o,
  output logic [5:0]         seg_index_o,
  output logic [16:0]        frac_out_o,
  output logic [30:0]        position_out_o,
  output logic               found_o,
  output logic [2:0]         status_o
);
  import asl_pkg::*;

  state_e state_q, state_d, ret_q, ret_d;

  logic [6:0]  cnt_reg_q;
  logic [16:0] sf_reg_q, ef_reg_q, eps_q;

  logic [2:0]         op_q, op_d;
  logic signed [31:0] s_q, s_d;
  logic [16:0]        f_q, f_d;
  logic [31:0]        id_q, id_d;

  logic [6:0] bptr_q, bptr_d, ptr_q, ptr_d, cnt_q, cnt_d, lag_q, lag_d;
  logic       sv_q, sv_d;
  logic [5:0] k_q, k_d;
  logic signed [31:0] b0_q, b0_d;

  logic signed [33:0] mul_a_q, mul_a_d, den_q, den_d;
  logic signed [18:0] mul_b_q, mul_b_d;
  logic signed [52:0] prod_q, prod_d;
  logic [NUM_W-1:0]   quo_q, quo_d;
  logic [DEN_W-1:0]   rem_q, rem_d, dmag_q, dmag_d;
  logic               neg_q, neg_d;
  logic [5:0]         step_q, step_d;

  logic        valid_q, valid_d, found_q, found_d;
  logic [5:0]  ridx_q, ridx_d;
  logic [16:0] rfrac_q, rfrac_d;
  logic [30:0] rpos_q, rpos_d;
  logic [2:0]  rst_q, rst_d;

  logic signed [31:0] bmem [0:MAX_SEG];
  logic [31:0]        idmem [0:MAX_SEG-1];
  logic signed [31:0] b_rd_q;
  logic [31:0]        id_rd_q;
  logic               b_we, id_we;
  logic [6:0]         b_raddr, id_addr;

  logic [6:0]  n;
  logic [16:0] sf, ef;
  logic signed [18:0] f0, f1, sfm, efp, fs;
  logic signed [33:0] span;
  logic [35:0]        trial;
  logic signed [52:0] qs, v;
  logic               hit;

  assign n  = (cnt_reg_q > 7'(MAX_SEG)) ? 7'(MAX_SEG) : cnt_reg_q;
  assign sf = (sf_reg_q > FRAC_ONE) ? FRAC_ONE : sf_reg_q;
  assign ef = (ef_reg_q > FRAC_ONE) ? FRAC_ONE : ef_reg_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_reg_q <= '0;
      sf_reg_q  <= '0;
      ef_reg_q  <= FRAC_ONE;
      eps_q     <= 17'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COUNT: cnt_reg_q <= cfg_data_i[6:0];
        CFG_START: sf_reg_q  <= cfg_data_i;
        CFG_END:   ef_reg_q  <= cfg_data_i;
        CFG_EPS:   eps_q     <= cfg_data_i;
        default:   eps_q     <= eps_q;
      endcase
    end
  end

  // tables, one registered read port each
  assign b_we    = (state_q == S_IDLE) && start_i && (op_i == OP_WRITE)
                   && (entry_index_i <= 7'(MAX_SEG));
  assign id_we   = (state_q == S_IDLE) && start_i && (op_i == OP_WRITE)
                   && (entry_index_i < 7'(MAX_SEG));
  assign b_raddr = (bptr_q > 7'(MAX_SEG)) ? 7'(MAX_SEG) : bptr_q;
  assign id_addr = (op_q == OP_FIRST) ? ptr_q : (n - 7'd1 - ptr_q);

  always_ff @(posedge clk_i) begin
    if (b_we) bmem[entry_index_i] <= arc_position_i;
    if (id_we) idmem[entry_index_i[5:0]] <= segment_id_i;
    b_rd_q  <= bmem[b_raddr];
    id_rd_q <= idmem[id_addr[5:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      valid_q <= 1'b0;
      bptr_q  <= '0;
      ptr_q   <= '0;
      sv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      valid_q <= valid_d;
      bptr_q  <= bptr_d;
      ptr_q   <= ptr_d;
      sv_q    <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    s_q     <= s_d;
    f_q     <= f_d;
    id_q    <= id_d;
    cnt_q   <= cnt_d;
    lag_q   <= lag_d;
    k_q     <= k_d;
    b0_q    <= b0_d;
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    den_q   <= den_d;
    prod_q  <= prod_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dmag_q  <= dmag_d;
    neg_q   <= neg_d;
    step_q  <= step_d;
    ridx_q  <= ridx_d;
    rfrac_q <= rfrac_d;
    rpos_q  <= rpos_d;
    found_q <= found_d;
    rst_q   <= rst_d;
  end

  // segment end fractions of the segment in k_q, or of the incoming index
  always_comb begin
    logic [6:0] seg;
    seg = (state_q == S_IDLE) ? entry_index_i : {1'b0, k_q};
    f0  = (seg == 7'd0) ? 19'(sf) : 19'sd0;
    f1  = (seg + 7'd1 == n) ? 19'(ef) : 19'(FRAC_ONE);
  end

  assign span  = 34'(b_rd_q) - 34'(b0_q);
  assign trial = {1'b0, rem_q, quo_q[NUM_W-1]} - {2'b00, dmag_q};
  assign qs    = neg_q ? (-53'(quo_q) - 53'(rem_q != '0)) : 53'(quo_q);
  assign sfm   = 19'(sf) - 19'(eps_q);
  assign efp   = 19'(ef) + 19'(eps_q);
  assign fs    = 19'(f_q);

  always_comb begin
    if (n == 7'd1)                 hit = (fs > sfm) && (fs < efp);
    else if (lag_q == 7'd0)        hit = (fs >= sfm);
    else if (lag_q + 7'd1 == n)    hit = (fs <= efp);
    else                           hit = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    op_d    = op_q;
    s_d     = s_q;
    f_d     = f_q;
    id_d    = id_q;
    bptr_d  = bptr_q;
    ptr_d   = ptr_q;
    sv_d    = sv_q;
    cnt_d   = cnt_q;
    lag_d   = lag_q;
    k_d     = k_q;
    b0_d    = b0_q;
    mul_a_d = mul_a_q;
    mul_b_d = mul_b_q;
    den_d   = den_q;
    prod_d  = prod_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dmag_d  = dmag_q;
    neg_d   = neg_q;
    step_d  = step_q;
    valid_d = 1'b0;
    ridx_d  = '0;
    rfrac_d = '0;
    rpos_d  = '0;
    found_d = 1'b0;
    rst_d   = ST_OK;
    v       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = op_i;
          s_d   = arc_position_i;
          f_d   = query_frac_i;
          id_d  = segment_id_i;
          case (op_i) inside
            OP_WRITE: begin
              valid_d = 1'b1;
              if (entry_index_i > 7'(MAX_SEG)) rst_d = ST_IDX;
            end
            OP_POS2PT: begin
              if (n == 7'd0) begin
                valid_d = 1'b1;
                rfrac_d = sf;
                rst_d   = ST_DEGEN;
              end else begin
                bptr_d  = n;
                ret_d   = S_TOP;
                state_d = S_WAIT;
              end
            end
            OP_PT2POS: begin
              ridx_d  = entry_index_i[5:0];
              rfrac_d = query_frac_i;
              k_d     = entry_index_i[5:0];
              if (n == 7'd0) begin
                valid_d = 1'b1;
                rst_d   = ST_DEGEN;
              end else if (entry_index_i >= n) begin
                valid_d = 1'b1;
                rst_d   = ST_IDX;
              end else if (query_frac_i > FRAC_ONE) begin
                valid_d = 1'b1;
                rst_d   = ST_FRAC;
              end else if (f1 == f0) begin
                valid_d = 1'b1;
                rst_d   = ST_ZERO;
              end else begin
                bptr_d  = entry_index_i;
                ret_d   = S_LO;
                state_d = S_WAIT;
              end
            end
            OP_FIRST, OP_LAST: begin
              ptr_d   = '0;
              sv_d    = 1'b0;
              state_d = S_IDSCAN;
            end
            default: valid_d = 1'b1;
          endcase
        end
      end

      S_WAIT: state_d = ret_q;

      S_TOP: begin
        if (s_q >= b_rd_q) begin
          valid_d = 1'b1;
          ridx_d  = 6'(n - 7'd1);
          rfrac_d = ef;
          state_d = S_IDLE;
        end else if (s_q <= 32'sd0) begin
          valid_d = 1'b1;
          rfrac_d = sf;
          state_d = S_IDLE;
        end else begin
          bptr_d  = '0;
          sv_d    = 1'b0;
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end

      // count boundaries at or below the position, one per cycle
      S_SCAN: begin
        if (sv_q && (b_rd_q <= s_q)) cnt_d = cnt_q + 7'd1;
        sv_d   = (bptr_q <= n);
        bptr_d = bptr_q + 7'd1;
        if (!sv_q && (bptr_q > n)) begin
          if (cnt_q == 7'd0)               k_d = '0;
          else if (cnt_q - 7'd1 > n - 7'd1) k_d = 6'(n - 7'd1);
          else                              k_d = 6'(cnt_q - 7'd1);
          bptr_d  = {1'b0, k_d};
          ret_d   = S_LO;
          state_d = S_WAIT;
        end
      end

      S_LO: begin
        b0_d    = b_rd_q;
        bptr_d  = {1'b0, k_q} + 7'd1;
        ret_d   = S_HI;
        state_d = S_WAIT;
      end

      S_HI: begin
        if (op_q == OP_POS2PT) begin
          if (span == 34'sd0) begin
            valid_d = 1'b1;
            ridx_d  = k_q;
            rfrac_d = 17'(f0);
            rst_d   = ST_ZERO;
            state_d = S_IDLE;
          end else begin
            mul_a_d = 34'(s_q) - 34'(b0_q);
            mul_b_d = f1 - f0;
            den_d   = span;
            state_d = S_MUL;
          end
        end else begin
          mul_a_d = span;
          mul_b_d = fs - f0;
          den_d   = 34'(f1 - f0);
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        prod_d  = 53'(mul_a_q) * 53'(mul_b_q);
        state_d = S_DIVI;
      end

      S_DIVI: begin
        neg_d   = prod_q[52] ^ den_q[33];
        quo_d   = prod_q[52] ? NUM_W'(-prod_q) : NUM_W'(prod_q);
        dmag_d  = den_q[33] ? DEN_W'(-den_q) : DEN_W'(den_q);
        rem_d   = '0;
        step_d  = '0;
        state_d = S_DIV;
      end

      // restoring divide, one quotient bit a cycle
      S_DIV: begin
        if (!trial[35]) begin
          rem_d = trial[33:0];
          quo_d = {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[32:0], quo_q[NUM_W-1]};
          quo_d = {quo_q[NUM_W-2:0], 1'b0};
        end
        step_d = step_q + 6'd1;
        if (step_q == 6'(NUM_W - 1)) state_d = S_FIN;
      end

      S_FIN: begin
        valid_d = 1'b1;
        ridx_d  = k_q;
        state_d = S_IDLE;
        if (op_q == OP_POS2PT) begin
          v = 53'(f0) + qs;
          if (v < 53'sd0)                 rfrac_d = '0;
          else if (v > 53'(FRAC_ONE))     rfrac_d = FRAC_ONE;
          else                            rfrac_d = v[16:0];
        end else begin
          v = 53'(b0_q) + qs;
          rfrac_d = f_q;
          if (v < 53'sd0)                 rpos_d = '0;
          else if (v > 53'(POS_CAP))      rpos_d = POS_CAP;
          else                            rpos_d = v[30:0];
        end
      end

      S_IDSCAN: begin
        if (sv_q && (id_rd_q == id_q) && hit) begin
          valid_d = 1'b1;
          ridx_d  = lag_q[5:0];
          rfrac_d = f_q;
          found_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          sv_d  = (ptr_q < n);
          lag_d = id_addr;
          ptr_d = ptr_q + 7'd1;
          if (!sv_q && (ptr_q >= n)) begin
            valid_d = 1'b1;
            rst_d   = ST_NOTFOUND;
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign valid_o        = valid_q;
  assign seg_index_o    = ridx_q;
  assign frac_out_o     = rfrac_q;
  assign position_out_o = rpos_q;
  assign found_o        = found_q;
  assign status_o       = rst_q;

endmodule

>>> tb/sv/asl_checker.sv
// asl_checker: watches the command, config and result channels of the segment locator,
// predicts every answer and compares it field by field; depends on asl_pkg
module asl_checker
  import asl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [2:0]         op_i,
  input  logic [6:0]         entry_index_i,
  input  logic signed [31:0] arc_position_i,
  input  logic [16:0]        query_frac_i,
  input  logic [31:0]        segment_id_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               valid_i,
  input  logic [5:0]         seg_index_i,
  input  logic [16:0]        frac_out_i,
  input  logic [30:0]        position_out_i,
  input  logic               found_i,
  input  logic [2:0]         status_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [5:0]  seg_index;
    logic [16:0] frac;
    logic [30:0] position;
    logic        found;
    status_e     status;
  } answer_t;

  localparam longint ONE = 65536;

  answer_t     expected_answers[$];
  longint      boundary_mirror[0:64];
  logic [31:0] id_mirror[0:63];
  longint      seg_count, start_frac, end_frac, epsilon;

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    if (b < 0) begin
      a = -a;
      b = -b;
    end
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // also applies table writes, so call once per accepted item
  function automatic answer_t locate_answer(logic [2:0] op, logic [6:0] idx_in,
                                            logic signed [31:0] pos, logic [16:0] frac_in,
                                            logic [31:0] id);
    longint n, sf, ef, s, f, idx, k, cnt, f0, f1, span, q, b0, p, i, t;
    longint r_idx, r_frac, r_pos, r_found;
    bit hit;
    answer_t a;
    n = seg_count > MAX_SEG ? MAX_SEG : seg_count;
    sf = start_frac > ONE ? ONE : start_frac;
    ef = end_frac > ONE ? ONE : end_frac;
    s = pos;
    f = frac_in;
    idx = idx_in;
    r_idx = 0;
    r_frac = 0;
    r_pos = 0;
    r_found = 0;
    a.status = ST_OK;
    if (op == OP_WRITE) begin
      if (idx <= MAX_SEG) begin
        boundary_mirror[idx] = s;
        if (idx < MAX_SEG) id_mirror[idx] = id;
      end else begin
        a.status = ST_IDX;
      end
    end else if (op == OP_POS2PT) begin
      if (n < 1) begin
        r_frac = sf;
        a.status = ST_DEGEN;
      end else if (s >= boundary_mirror[n]) begin
        r_idx = n - 1;
        r_frac = ef;
      end else if (s <= 0) begin
        r_frac = sf;
      end else begin
        cnt = 0;
        for (k = 0; k <= n; k++)
          if (boundary_mirror[k] <= s) cnt++;
        k = cnt - 1;
        if (k < 0) k = 0;
        if (k > n - 1) k = n - 1;
        f0 = (k == 0) ? sf : 0;
        f1 = (k + 1 == n) ? ef : ONE;
        span = boundary_mirror[k + 1] - boundary_mirror[k];
        r_idx = k;
        if (span == 0) begin
          r_frac = f0;
          a.status = ST_ZERO;
        end else begin
          q = f0 + floor_quot((f1 - f0) * (s - boundary_mirror[k]), span);
          if (q < 0) q = 0;
          if (q > ONE) q = ONE;
          r_frac = q;
        end
      end
    end else if (op == OP_PT2POS) begin
      r_idx = idx;
      r_frac = f;
      if (n < 1) a.status = ST_DEGEN;
      else if (idx >= n) a.status = ST_IDX;
      else if (f > ONE) a.status = ST_FRAC;
      else begin
        f0 = (idx == 0) ? sf : 0;
        f1 = (idx + 1 == n) ? ef : ONE;
        if (f1 == f0) a.status = ST_ZERO;
        else begin
          b0 = boundary_mirror[idx];
          p = b0 + floor_quot((boundary_mirror[idx + 1] - b0) * (f - f0), f1 - f0);
          if (p < 0) p = 0;
          if (p > 64'h7fffffff) p = 64'h7fffffff;
          r_pos = p;
        end
      end
    end else if (op == OP_FIRST || op == OP_LAST) begin
      hit = 0;
      for (t = 0; t < n && !hit; t++) begin
        i = (op == OP_FIRST) ? t : (n - 1 - t);
        if (id_mirror[i] == id) begin
          if (n == 1) hit = (f > sf - epsilon) && (f < ef + epsilon);
          else if (i == 0) hit = (f >= sf - epsilon);
          else if (i + 1 == n) hit = (f <= ef + epsilon);
          else hit = 1;
          if (hit) begin
            r_idx = i;
            r_frac = f;
            r_found = 1;
          end
        end
      end
      if (!hit) a.status = ST_NOTFOUND;
    end
    a.seg_index = r_idx[5:0];
    a.frac = r_frac[16:0];
    a.position = r_pos[30:0];
    a.found = r_found[0];
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    if (!rst_ni) begin
      expected_answers.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      seg_count = 0;
      start_frac = 0;
      end_frac = ONE;
      epsilon = 1;
    end else begin
      if (valid_i) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: result with nothing expected: idx %0d frac %0d pos %0d st %0d",
                   $time, seg_index_i, frac_out_i, position_out_i, status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_a = expected_answers.pop_front();
          if (exp_a.seg_index !== seg_index_i || exp_a.frac !== frac_out_i ||
              exp_a.position !== position_out_i || exp_a.found !== found_i ||
              exp_a.status !== status_i) begin
            $display("%0t: mismatch exp idx %0d frac %0d pos %0d found %0d st %0d",
                     $time, exp_a.seg_index, exp_a.frac, exp_a.position, exp_a.found,
                     exp_a.status);
            $display("%0t:          got idx %0d frac %0d pos %0d found %0d st %0d",
                     $time, seg_index_i, frac_out_i, position_out_i, found_i, status_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        expected_answers.insert(expected_answers.size(),
                                locate_answer(op_i, entry_index_i, arc_position_i,
                                              query_frac_i, segment_id_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COUNT: seg_count = cfg_data_i[6:0];
          CFG_START: start_frac = cfg_data_i;
          CFG_END:   end_frac = cfg_data_i;
          CFG_EPS:   epsilon = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= expected_answers.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// tb_top: stimulus for arclength_segment_locator_top with asl_checker beside it
// depends on asl_pkg, asl_checker and the block itself
module tb_top;
  import asl_pkg::*;

  localparam logic [2:0] OP_SPARE = 3'd5;
  localparam longint POS_MAX = 64'h7fffffff;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic [2:0]         op = OP_WRITE;
  logic [6:0]         entry_index = 0;
  logic signed [31:0] arc_position = 0;
  logic [16:0]        query_frac = 0;
  logic [31:0]        segment_id = 0;
  logic               cfg_we = 0;
  logic [1:0]         cfg_idx = CFG_COUNT;
  logic [16:0]        cfg_data = 0;
  logic               busy, valid, found;
  logic [5:0]         seg_index;
  logic [16:0]        frac_out;
  logic [30:0]        position_out;
  logic [2:0]         status;
  int                 fail_count, pending;
  int                 items_sent = 0, phases_run = 0;
  bit                 quiet_sender = 0;
  longint             bounds[0:64];
  int                 path_len = 0;

  arclength_segment_locator_top i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .op_i(op),
    .entry_index_i(entry_index), .arc_position_i(arc_position),
    .query_frac_i(query_frac), .segment_id_i(segment_id), .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data), .valid_o(valid), .seg_index_o(seg_index),
    .frac_out_o(frac_out), .position_out_o(position_out), .found_o(found),
    .status_o(status)
  );

  asl_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .op_i(op),
    .entry_index_i(entry_index), .arc_position_i(arc_position),
    .query_frac_i(query_frac), .segment_id_i(segment_id), .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data), .valid_i(valid), .seg_index_i(seg_index),
    .frac_out_i(frac_out), .position_out_i(position_out), .found_i(found),
    .status_i(status), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("arclength_segment_locator_top regression: fail");
    $finish;
  end

  task automatic send_item(logic [2:0] o, int idx, longint pos, int fr,
                           logic [31:0] id);
    int gap, r;
    @(negedge clk);
    start = 1;
    op = o;
    entry_index = idx[6:0];
    arc_position = pos[31:0];
    query_frac = fr[16:0];
    segment_id = id;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    r = $urandom_range(0, 99);
    if (quiet_sender || r < 55) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 80);
    if (gap > 0) begin
      @(negedge clk);
      start = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // hold off until every answer is in, then let the block go quiet
  task automatic drain;
    @(negedge clk);
    start = 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_e r, int value);
    @(negedge clk);
    cfg_we = 1;
    cfg_idx = r;
    cfg_data = value[16:0];
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic int pick_fraction();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 65536);
    if (r < 85) return 0;
    if (r < 93) return 65536;
    return $urandom_range(0, 131071);
  endfunction

  function automatic int pick_reg_fraction(int sel);
    case (sel % 5)
      0: return 0;
      1: return 65536;
      2: return 131071;
      3: return $urandom_range(0, 65536);
      default: return $urandom_range(0, 131071);
    endcase
  endfunction

  // ascending boundaries with a few flat segments; sometimes plain noise
  task automatic load_path(bit scrambled);
    longint b;
    int e, r;
    r = $urandom_range(0, 9);
    b = (r < 7) ? $urandom_range(0, 5000) : (r < 9 ? 0 : -longint'($urandom_range(1, 1000000)));
    for (e = 0; e <= 64; e++) begin
      if (scrambled) b = longint'($signed($urandom()));
      bounds[e] = b;
      r = $urandom_range(0, 99);
      send_item(OP_WRITE, e, b, $urandom_range(0, 131071),
                (r < 85) ? $urandom_range(0, 7) : $urandom());
      r = $urandom_range(0, 99);
      if (r < 10) b = b;
      else if (r < 85) b = b + $urandom_range(1, 1 << 20);
      else b = b + $urandom_range(1 << 20, 1 << 27);
      if (b > POS_MAX) b = POS_MAX;
    end
  endtask

  task automatic random_query();
    int r, k;
    longint pos;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      k = (path_len > 0) ? $urandom_range(0, path_len - 1) : 0;
      r = $urandom_range(0, 99);
      if (r < 70) pos = bounds[k] + $urandom_range(0, 1 << 21) - 1000;
      else if (r < 82) pos = bounds[$urandom_range(0, path_len)];
      else pos = longint'($signed($urandom()));
      send_item(OP_POS2PT, $urandom_range(0, 127), pos, $urandom_range(0, 131071), $urandom());
    end else if (r < 65) begin
      k = ($urandom_range(0, 99) < 85 && path_len > 0) ? $urandom_range(0, path_len - 1)
                                                     : $urandom_range(0, 127);
      send_item(OP_PT2POS, k, $urandom(), pick_fraction(), $urandom());
    end else if (r < 90) begin
      send_item((r < 77) ? OP_FIRST : OP_LAST, $urandom_range(0, 127), $urandom(),
                pick_fraction(), ($urandom_range(0, 9) < 9) ? $urandom_range(0, 8) : $urandom());
    end else if (r < 95) begin
      // overwrite one entry with something arbitrary
      k = $urandom_range(0, 64);
      bounds[k] = longint'($signed($urandom()));
      send_item(OP_WRITE, k, bounds[k], $urandom_range(0, 131071), $urandom());
    end else if (r < 97) begin
      send_item(OP_WRITE, $urandom_range(65, 127), $urandom(), $urandom_range(0, 131071),
                $urandom());
    end else begin
      send_item(OP_SPARE + 3'($urandom_range(0, 2)), $urandom_range(0, 127), $urandom(),
                $urandom_range(0, 131071), $urandom());
    end
  endtask

  initial begin
    int p, q, cnt, counts[6];
    counts = '{1, 64, 0, 2, 127, 5};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // empty path, spare codes and a bad write before anything is loaded
    send_item(OP_POS2PT, 0, 32'h00001000, 0, 0);
    send_item(OP_PT2POS, 127, 0, 131071, 0);
    send_item(OP_FIRST, 0, 0, 0, 32'hffffffff);
    send_item(OP_LAST, 0, 0, 65536, 0);
    send_item(OP_SPARE, 127, 32'hffffffff, 131071, 32'hffffffff);
    send_item(OP_SPARE + 3'd2, 0, 0, 0, 0);
    send_item(OP_WRITE, 127, 32'h7fffffff, 0, 32'hffffffff);
    load_path(0);
    drain();
    write_reg(CFG_COUNT, 64);
    path_len = 64;
    send_item(OP_POS2PT, 0, 32'h80000000, 0, 0);
    send_item(OP_POS2PT, 0, 0, 0, 0);
    send_item(OP_POS2PT, 0, 32'h7fffffff, 0, 0);
    send_item(OP_POS2PT, 0, bounds[1] + 1, 0, 0);
    send_item(OP_PT2POS, 63, 0, 65536, 0);
    send_item(OP_PT2POS, 0, 0, 0, 0);
    send_item(OP_PT2POS, 63, 0, 65537, 0);
    send_item(OP_PT2POS, 64, 0, 0, 0);
    send_item(OP_FIRST, 0, 0, 0, 3);
    send_item(OP_LAST, 0, 0, 65536, 3);
    send_item(OP_FIRST, 0, 0, 1, 32'hdeadbeef);

    for (p = 0; p < 14; p++) begin
      drain();
      phases_run++;
      quiet_sender = (p % 4 == 3);
      cnt = (p < 6) ? counts[p] : $urandom_range(1, 64);
      write_reg(CFG_COUNT, cnt);
      write_reg(CFG_START, pick_reg_fraction(p + $urandom_range(0, 4) * (p > 4)));
      write_reg(CFG_END, pick_reg_fraction(p + 1 + $urandom_range(0, 4) * (p > 4)));
      write_reg(CFG_EPS, (p % 3 == 0) ? 0 : (p % 3 == 1 ? 65536 : $urandom_range(0, 131071)));
      path_len = (cnt > 64) ? 64 : cnt;
      load_path(p % 6 == 5);
      for (q = 0; q < 70; q++) random_query();
    end
    drain();
    repeat (250) @(posedge clk);

    $display("covered %0d items over %0d register settings, all five query kinds",
             items_sent, phases_run);
    if (fail_count == 0 && pending == 0)
      $display("arclength_segment_locator_top regression: pass");
    else
      $display("arclength_segment_locator_top regression: fail");
    $finish;
  end

endmodule
